// ----- hw/rtl/tsw_pkg.sv -----
// ----------------------------------------------------------------------------
// tsw_pkg: shared types and helpers of the wrapping bilinear texture sampler
// Holds the register codes, the command word passed from the front end to the
// back end, and the fixed-point blend used by the back end.
// ----------------------------------------------------------------------------
package tsw_pkg;

  localparam int MaxWidth  = 64;
  localparam int MaxHeight = 64;
  localparam int FracBits  = 8;
  localparam int XBits     = $clog2(MaxWidth);
  localparam int YBits     = $clog2(MaxHeight);
  localparam int AddrBits  = XBits + YBits;
  localparam int Depth     = MaxWidth * MaxHeight;

  // configuration register indexes
  localparam logic [2:0] REG_TEX_WIDTH   = 3'd0;
  localparam logic [2:0] REG_TEX_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_WRAP_S      = 3'd2;
  localparam logic [2:0] REG_WRAP_T      = 3'd3;
  localparam logic [2:0] REG_FILTER_MODE = 3'd4;

  // wrap modes
  localparam logic [1:0] WRAP_CLAMP  = 2'd0;
  localparam logic [1:0] WRAP_REPEAT = 2'd1;
  localparam logic [1:0] WRAP_MIRROR = 2'd2;

  // command kinds
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // filter modes
  localparam logic FILT_NEAREST  = 1'b0;
  localparam logic FILT_BILINEAR = 1'b1;

  typedef struct packed {
    logic [6:0] width;   // effective size, 1..64
    logic [6:0] height;
    logic [1:0] wrap_s;
    logic [1:0] wrap_t;
    logic       filter;
  } cfg_t;

  // one request for the back end
  typedef struct packed {
    logic                is_write;
    logic                nearest;
    logic [AddrBits-1:0] addr00;   // also the write or nearest address
    logic [AddrBits-1:0] addr10;
    logic [AddrBits-1:0] addr01;
    logic [AddrBits-1:0] addr11;
    logic [FracBits-1:0] fu;
    logic [FracBits-1:0] fv;
    logic [31:0]         data;
  } req_t;

  // rounded linear blend of two 8-bit channels
  function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                       input logic [FracBits-1:0] f);
    logic [FracBits:0]    omf;
    logic [FracBits+9:0]  acc;
    omf = (FracBits+1)'(1 << FracBits) - {1'b0, f};
    acc = ({{(FracBits+2){1'b0}}, a} * {9'b0, omf})
        + ({{(FracBits+2){1'b0}}, b} * {10'b0, f})
        + (FracBits+10)'(1 << (FracBits-1));
    lerp8 = acc[FracBits+7:FracBits];
  endfunction

endpackage

// ----- hw/rtl/tsw_queue.sv -----
// ----------------------------------------------------------------------------
// tsw_queue: two-entry request queue
// Decouples the coordinate front end from the texel back end.
// ----------------------------------------------------------------------------
module tsw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  tsw_pkg::req_t push_req,
  output logic          pop_valid,
  input  logic          pop_ready,
  output tsw_pkg::req_t pop_req
);

  tsw_pkg::req_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_req    = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_req;
  end

endmodule

// ----- hw/rtl/tsw_front.sv -----
// ----------------------------------------------------------------------------
// tsw_front: coordinate front end
// Scales the coordinates to texel space, wraps each axis and forms the texel
// addresses and fractions of a request.
// ----------------------------------------------------------------------------
module tsw_front (
  input  logic          clk,
  input  logic          rst_n,
  input  tsw_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          cmd,
  input  logic [31:0]   s_coord,
  input  logic [31:0]   t_coord,
  input  logic [5:0]    texel_x,
  input  logic [5:0]    texel_y,
  input  logic [31:0]   texel_rgba,
  output logic          q_valid,
  input  logic          q_ready,
  output tsw_pkg::req_t q_req
);

  // products registered in the first stage
  typedef struct packed {
    logic signed [39:0] full;   // coord * n
    logic [22:0]        rep;    // n * (coord mod 1)
    logic [23:0]        mir;    // n * (coord mod 2)
  } prod_t;

  logic        s1_v_r;
  logic        s1_cmd_r;
  prod_t       s1_u_r, s1_v2_r;
  logic [5:0]  s1_x_r, s1_y_r;
  logic [31:0] s1_data_r;

  assign in_ready = !s1_v_r || q_ready;
  assign q_valid  = s1_v_r;

  function automatic prod_t mul_axis(input logic [31:0] c, input logic [6:0] n);
    prod_t p;
    p.full = 40'($signed(c)) * 40'($signed({1'b0, n}));
    p.rep  = 23'(n) * 23'(c[15:0]);
    p.mir  = 24'(n) * 24'(c[16:0]);
    mul_axis = p;
  endfunction

  // wrap one axis, result is c in unsigned Q.16
  function automatic logic [22:0] wrap_axis(input prod_t p, input logic [6:0] n,
                                            input logic [1:0] mode);
    logic signed [40:0] cs;
    logic [21:0]        lim;
    logic signed [24:0] rv;
    logic signed [25:0] mv;
    logic [22:0]        per;
    logic [23:0]        per2;
    logic [22:0]        res;
    cs   = 41'(p.full) - 41'sd32768;
    lim  = {6'(n - 7'd1), 16'h0000};
    rv   = $signed({2'b00, p.rep}) - 25'sd32768;
    mv   = $signed({2'b00, p.mir}) - 26'sd32768;
    per  = {n, 16'h0000};
    per2 = {n, 17'h00000};
    case (mode)
      tsw_pkg::WRAP_REPEAT: begin
        if (rv < 0) rv = rv + $signed({2'b00, per});
        res = rv[22:0];
      end
      tsw_pkg::WRAP_MIRROR: begin
        if (mv < 0) mv = mv + $signed({2'b00, per2});
        if (mv < $signed({3'b000, per})) res = mv[22:0];
        else res = 23'(per2 - mv[23:0]);
      end
      default: begin
        if (cs < 0) res = '0;
        else if (cs > $signed({19'b0, lim})) res = {1'b0, lim};
        else res = cs[22:0];
      end
    endcase
    wrap_axis = res;
  endfunction

  function automatic logic [6:0] clamp_idx(input logic [7:0] i, input logic [6:0] nm1);
    clamp_idx = (i > {1'b0, nm1}) ? nm1 : i[6:0];
  endfunction

  // first stage: multiply
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (in_ready) s1_v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd_r  <= cmd;
      s1_u_r    <= mul_axis(s_coord, cfg.width);
      s1_v2_r   <= mul_axis(t_coord, cfg.height);
      s1_x_r    <= texel_x;
      s1_y_r    <= texel_y;
      s1_data_r <= texel_rgba;
    end
  end

  // second stage: wrap and index, feeds the queue
  logic [22:0] cu, cv;
  logic [23:0] nu, nv;
  logic [6:0]  wm1, hm1, x0, y0, x1, y1, xn, yn;

  always_comb begin
    wm1 = cfg.width - 7'd1;
    hm1 = cfg.height - 7'd1;
    cu  = wrap_axis(s1_u_r, cfg.width, cfg.wrap_s);
    cv  = wrap_axis(s1_v2_r, cfg.height, cfg.wrap_t);
    nu  = {1'b0, cu} + 24'd32768;
    nv  = {1'b0, cv} + 24'd32768;
    x0  = clamp_idx({1'b0, cu[22:16]}, wm1);
    y0  = clamp_idx({1'b0, cv[22:16]}, hm1);
    x1  = (x0 == wm1) ? wm1 : x0 + 7'd1;
    y1  = (y0 == hm1) ? hm1 : y0 + 7'd1;
    xn  = clamp_idx(nu[23:16], wm1);
    yn  = clamp_idx(nv[23:16], hm1);

    q_req          = '0;
    q_req.data     = s1_data_r;
    q_req.fu       = cu[15:16-tsw_pkg::FracBits];
    q_req.fv       = cv[15:16-tsw_pkg::FracBits];
    q_req.addr10   = {y0[5:0], x1[5:0]};
    q_req.addr01   = {y1[5:0], x0[5:0]};
    q_req.addr11   = {y1[5:0], x1[5:0]};
    if (s1_cmd_r == tsw_pkg::CMD_WRITE) begin
      q_req.is_write = 1'b1;
      q_req.addr00   = {s1_y_r, s1_x_r};
    end else if (cfg.filter == tsw_pkg::FILT_NEAREST) begin
      q_req.nearest  = 1'b1;
      q_req.addr00   = {yn[5:0], xn[5:0]};
    end else begin
      q_req.addr00   = {y0[5:0], x0[5:0]};
    end
  end

endmodule

// ----- hw/rtl/tsw_back.sv -----
// ----------------------------------------------------------------------------
// tsw_back: texel back end
// Owns the texel memory, issues up to four reads per request and blends them.
// ----------------------------------------------------------------------------
module tsw_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  tsw_pkg::req_t q_req,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   out_data
);

  logic [31:0] mem [tsw_pkg::Depth];

  logic        adv;
  logic [1:0]  ph_r, ph_nxt;
  logic        last;
  logic [tsw_pkg::AddrBits-1:0] addr;

  // issue stage tags
  logic        iss_v_r, iss_last_r, iss_near_r;
  logic [1:0]  iss_ph_r;
  logic [tsw_pkg::FracBits-1:0] iss_fu_r, iss_fv_r;
  logic [31:0] rd_r;

  // collected texels
  logic [31:0] t00_r, t10_r, t01_r;

  // horizontal blend stage
  logic        b1_v_r, b1_near_r;
  logic [31:0] b1_lo_r, b1_hi_r;
  logic [tsw_pkg::FracBits-1:0] b1_fv_r;

  logic        out_v_r;
  logic [31:0] out_d_r;

  assign adv       = !out_v_r || out_ready;
  assign last      = q_req.is_write || q_req.nearest || (ph_r == 2'd3);
  assign q_ready   = adv && last;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  always_comb begin
    case (ph_r)
      2'd1:    addr = q_req.addr10;
      2'd2:    addr = q_req.addr01;
      2'd3:    addr = q_req.addr11;
      default: addr = q_req.addr00;
    endcase
    ph_nxt = ph_r;
    if (adv && q_valid) ph_nxt = last ? 2'd0 : ph_r + 2'd1;
  end

  // memory port: one write or one read per cycle while the output is not stalled
  always_ff @(posedge clk) begin
    if (adv && q_valid) begin
      if (q_req.is_write) mem[addr] <= q_req.data;
      else rd_r <= mem[addr];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= 2'd0;
      iss_v_r <= 1'b0;
      b1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      if (adv) begin
        iss_v_r <= q_valid && !q_req.is_write;
        b1_v_r  <= iss_v_r && iss_last_r;
        out_v_r <= b1_v_r;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      iss_last_r <= last;
      iss_near_r <= q_req.nearest;
      iss_ph_r   <= ph_r;
      iss_fu_r   <= q_req.fu;
      iss_fv_r   <= q_req.fv;
      if (iss_v_r) begin
        case (iss_ph_r)
          2'd0:    t00_r <= rd_r;
          2'd1:    t10_r <= rd_r;
          2'd2:    t01_r <= rd_r;
          default: ;
        endcase
      end
      b1_near_r <= iss_near_r;
      b1_fv_r   <= iss_fv_r;
      // nearest passes the texel through, bilinear blends along x
      if (iss_near_r) b1_lo_r <= rd_r;
      else begin
        for (int ch = 0; ch < 4; ch++) begin
          b1_lo_r[ch*8 +: 8] <= tsw_pkg::lerp8(t00_r[ch*8 +: 8], t10_r[ch*8 +: 8], iss_fu_r);
        end
      end
      for (int ch = 0; ch < 4; ch++) begin
        b1_hi_r[ch*8 +: 8] <= tsw_pkg::lerp8(t01_r[ch*8 +: 8], rd_r[ch*8 +: 8], iss_fu_r);
      end
      if (b1_near_r) out_d_r <= b1_lo_r;
      else begin
        for (int ch = 0; ch < 4; ch++) begin
          out_d_r[ch*8 +: 8] <= tsw_pkg::lerp8(b1_lo_r[ch*8 +: 8], b1_hi_r[ch*8 +: 8], b1_fv_r);
        end
      end
    end
  end

endmodule

// ----- hw/rtl/texture_sampler_wrap_bilinear_top.sv -----
// ----------------------------------------------------------------------------
// texture_sampler_wrap_bilinear_top: RGBA8 texture sampler with wrap modes
// Stores texels written over the input stream and returns nearest or bilinear
// samples at normalized Q16.16 coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : request stream. in_tuser = cmd (0 write texel, 1 sample).
//           A write stores texel_rgba at (texel_x, texel_y) and gives no result.
//   out_* : one RGBA8 result per sample, red in the low byte.
//   cfg_* : register writes (width, height, wrap_s, wrap_t, filter_mode); only
//           while the block is idle. cfg_ready is always high.
// The single texel memory port sets the throughput: a bilinear sample reads it
// four times, a nearest sample reads it once and a write uses it once.
// A front end (multiply, wrap, index) feeds a two-entry queue; the back end
// reads the memory and blends in two registered stages.
// Reset clears all control state and restores register defaults; the texel
// memory is not cleared and must be written before it is sampled.
// When out_tready is low the back end holds, the queue fills and in_tready
// drops; nothing is lost.
// ----------------------------------------------------------------------------
module texture_sampler_wrap_bilinear_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // s_coord[31:0], t_coord[63:32], texel_x[69:64], texel_y[75:70],
  // texel_rgba[107:76], zero pad [111:108]
  input  logic [111:0] in_tdata,
  // cmd[0]
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  output logic [31:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_addr,
  input  logic [6:0]   cfg_data
);

  logic [6:0] width_r, height_r;
  logic [1:0] wrap_s_r, wrap_t_r;
  logic       filter_r;
  tsw_pkg::cfg_t cfg;
  logic          q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  tsw_pkg::req_t q_in_req, q_out_req;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 7'd64;
      height_r <= 7'd64;
      wrap_s_r <= tsw_pkg::WRAP_REPEAT;
      wrap_t_r <= tsw_pkg::WRAP_REPEAT;
      filter_r <= tsw_pkg::FILT_BILINEAR;
    end else if (cfg_valid) begin
      case (cfg_addr)
        tsw_pkg::REG_TEX_WIDTH:   width_r  <= cfg_data;
        tsw_pkg::REG_TEX_HEIGHT:  height_r <= cfg_data;
        tsw_pkg::REG_WRAP_S:      wrap_s_r <= cfg_data[1:0];
        tsw_pkg::REG_WRAP_T:      wrap_t_r <= cfg_data[1:0];
        tsw_pkg::REG_FILTER_MODE: filter_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective sizes, code 3 treated as clamp
  always_comb begin
    cfg.width  = (width_r == 7'd0) ? 7'd1 :
                 (width_r > 7'(tsw_pkg::MaxWidth)) ? 7'(tsw_pkg::MaxWidth) : width_r;
    cfg.height = (height_r == 7'd0) ? 7'd1 :
                 (height_r > 7'(tsw_pkg::MaxHeight)) ? 7'(tsw_pkg::MaxHeight) : height_r;
    cfg.wrap_s = wrap_s_r;
    cfg.wrap_t = wrap_t_r;
    cfg.filter = filter_r;
  end

  tsw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .cmd        (in_tuser[0]),
    .s_coord    (in_tdata[31:0]),
    .t_coord    (in_tdata[63:32]),
    .texel_x    (in_tdata[69:64]),
    .texel_y    (in_tdata[75:70]),
    .texel_rgba (in_tdata[107:76]),
    .q_valid    (q_in_valid),
    .q_ready    (q_in_ready),
    .q_req      (q_in_req)
  );

  tsw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_req   (q_in_req),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_req    (q_out_req)
  );

  tsw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_out_valid),
    .q_ready   (q_out_ready),
    .q_req     (q_out_req),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

// ----- sim/texture_sampler_wrap_bilinear_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_sampler_wrap_bilinear_top_tb: texture sampler stream testbench
// Loads texels, samples them under every wrap mode, a range of sizes and both
// filters, and checks each RGBA result against a sampler modeled in the bench.
// ----------------------------------------------------------------------------
module texture_sampler_wrap_bilinear_top_tb;

  // per-texel shadow of the sampler: contents, written flags, registers
  class sample_scoreboard;
    logic [31:0] texels [tsw_pkg::Depth];
    bit          written [tsw_pkg::Depth];
    logic [6:0]  width_reg, height_reg;
    logic [1:0]  wrap_s_reg, wrap_t_reg;
    logic        filter_reg;
    logic [31:0] pending_rgba [$];
    int          errors;

    function new();
      width_reg = 7'd64; height_reg = 7'd64;
      wrap_s_reg = tsw_pkg::WRAP_REPEAT; wrap_t_reg = tsw_pkg::WRAP_REPEAT;
      filter_reg = tsw_pkg::FILT_BILINEAR;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [6:0] val);
      case (idx)
        tsw_pkg::REG_TEX_WIDTH:   width_reg = val;
        tsw_pkg::REG_TEX_HEIGHT:  height_reg = val;
        tsw_pkg::REG_WRAP_S:      wrap_s_reg = val[1:0];
        tsw_pkg::REG_WRAP_T:      wrap_t_reg = val[1:0];
        tsw_pkg::REG_FILTER_MODE: filter_reg = val[0];
        default: ;
      endcase
    endfunction

    function longint eff_size(logic [6:0] r, longint maxv);
      longint n;
      n = r;
      if (n < 1) n = 1;
      if (n > maxv) n = maxv;
      return n;
    endfunction

    function longint wrap_axis(longint c, longint n, logic [1:0] mode);
      longint p, r;
      p = n * 65536;
      if (mode == tsw_pkg::WRAP_REPEAT) begin
        r = c % p;
        if (r < 0) r += p;
        return r;
      end
      if (mode == tsw_pkg::WRAP_MIRROR) begin
        r = c % (2 * p);
        if (r < 0) r += 2 * p;
        return (r < p) ? r : 2 * p - r;
      end
      if (c < 0) return 0;
      if (c > (n - 1) * 65536) return (n - 1) * 65536;
      return c;
    endfunction

    function int blend(int a, int b, int f);
      return (a * (256 - f) + b * f + 128) >> 8;
    endfunction

    function logic [31:0] texel_at(longint x, longint y);
      return texels[y * tsw_pkg::MaxWidth + x];
    endfunction

    // texel corners and fractions of a sample under the current registers
    function void locate(logic [31:0] s, logic [31:0] t,
                         output longint x0, y0, x1, y1, output int fu, fv);
      longint w, h, cu, cv;
      w = eff_size(width_reg, tsw_pkg::MaxWidth);
      h = eff_size(height_reg, tsw_pkg::MaxHeight);
      cu = wrap_axis(longint'($signed(s)) * w - 32768, w, wrap_s_reg);
      cv = wrap_axis(longint'($signed(t)) * h - 32768, h, wrap_t_reg);
      if (filter_reg == tsw_pkg::FILT_NEAREST) begin
        x0 = (cu + 32768) / 65536; y0 = (cv + 32768) / 65536;
        if (x0 > w - 1) x0 = w - 1;
        if (y0 > h - 1) y0 = h - 1;
        x1 = x0; y1 = y0; fu = 0; fv = 0;
      end else begin
        x0 = cu / 65536; y0 = cv / 65536;
        fu = (cu & 'hFFFF) >> 8; fv = (cv & 'hFFFF) >> 8;
        if (x0 > w - 1) x0 = w - 1;
        if (y0 > h - 1) y0 = h - 1;
        x1 = (x0 + 1 > w - 1) ? w - 1 : x0 + 1;
        y1 = (y0 + 1 > h - 1) ? h - 1 : y0 + 1;
      end
    endfunction

    // true when every texel the sample touches holds written data
    function bit can_sample(logic [31:0] s, logic [31:0] t);
      longint x0, y0, x1, y1;
      int fu, fv;
      locate(s, t, x0, y0, x1, y1, fu, fv);
      return written[y0 * tsw_pkg::MaxWidth + x0] && written[y0 * tsw_pkg::MaxWidth + x1] &&
             written[y1 * tsw_pkg::MaxWidth + x0] && written[y1 * tsw_pkg::MaxWidth + x1];
    endfunction

    // coordinate that lands just right of texel 0 in every wrap mode
    function logic [31:0] safe_coord(bit vertical);
      longint n;
      n = vertical ? eff_size(height_reg, tsw_pkg::MaxHeight)
                   : eff_size(width_reg, tsw_pkg::MaxWidth);
      return 32'((32768 + n - 1) / n);
    endfunction

    // note an accepted request; samples queue their expected color
    function void note_request(logic cmd, logic [111:0] d);
      longint x0, y0, x1, y1;
      int fu, fv, lo, hi;
      logic [31:0] t00, t10, t01, t11, res;
      if (cmd == tsw_pkg::CMD_WRITE) begin
        texels[{d[75:70], d[69:64]}] = d[107:76];
        written[{d[75:70], d[69:64]}] = 1;
        return;
      end
      locate(d[31:0], d[63:32], x0, y0, x1, y1, fu, fv);
      if (filter_reg == tsw_pkg::FILT_NEAREST) begin
        res = texel_at(x0, y0);
      end else begin
        t00 = texel_at(x0, y0); t10 = texel_at(x1, y0);
        t01 = texel_at(x0, y1); t11 = texel_at(x1, y1);
        for (int ch = 0; ch < 4; ch++) begin
          lo = blend(t00[ch*8 +: 8], t10[ch*8 +: 8], fu);
          hi = blend(t01[ch*8 +: 8], t11[ch*8 +: 8], fu);
          res[ch*8 +: 8] = 8'(blend(lo, hi, fv));
        end
      end
      pending_rgba.push_back(res);
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] exp_rgba;
      if (pending_rgba.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_rgba = pending_rgba.pop_front();
      for (int ch = 0; ch < 4; ch++)
        if (got[ch*8 +: 8] !== exp_rgba[ch*8 +: 8]) begin
          $display("%0t: channel %0d expected %h actual %h", $time, ch,
                   exp_rgba[ch*8 +: 8], got[ch*8 +: 8]);
          errors++;
        end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [31:0]  out_tdata;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [2:0]   cfg_addr = '0;
  logic [6:0]   cfg_data = '0;

  sample_scoreboard color_sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cur_w = 64, cur_h = 64;

  texture_sampler_wrap_bilinear_top u_top (.*);

  always #10 clk = ~clk;

  // receiver: random back-pressure, results checked at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) color_sb.check_result(out_tdata);
  end
  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // one request, held until accepted, with random idle gaps ahead
  task automatic send_request(logic cmd, logic [111:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1; in_tuser <= cmd; in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    color_sb.note_request(cmd, d);
    @(negedge clk);
  endtask

  task automatic write_texel(int x, int y, logic [31:0] rgba);
    send_request(tsw_pkg::CMD_WRITE, {4'b0, rgba, 6'(y), 6'(x), 64'b0});
  endtask

  // samples that would touch unwritten texels move next to texel 0
  task automatic sample_at(logic [31:0] s, logic [31:0] t);
    logic [31:0] s_use, t_use;
    s_use = s; t_use = t;
    if (!color_sb.can_sample(s_use, t_use)) begin
      s_use = color_sb.safe_coord(1'b0);
      t_use = color_sb.safe_coord(1'b1);
    end
    send_request(tsw_pkg::CMD_SAMPLE, {4'b0, $urandom(), 12'($urandom()), t_use, s_use});
  endtask

  // drain all results, then let the pipeline settle before reconfiguring
  task automatic drain;
    in_tvalid <= 0;
    while (color_sb.pending_rgba.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [6:0] val);
    cfg_valid <= 1; cfg_addr <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    color_sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic configure(int w, int h, logic [1:0] ws, logic [1:0] wt, logic f);
    drain();
    write_reg(tsw_pkg::REG_TEX_WIDTH, 7'(w));
    write_reg(tsw_pkg::REG_TEX_HEIGHT, 7'(h));
    write_reg(tsw_pkg::REG_WRAP_S, 7'(ws));
    write_reg(tsw_pkg::REG_WRAP_T, 7'(wt));
    write_reg(tsw_pkg::REG_FILTER_MODE, 7'(f));
    cfg_valid <= 0;
    cur_w = w; cur_h = h;
  endtask

  // coordinate mostly near [-3,3] textures, sometimes the full range
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      2: return 32'($signed($urandom_range(196608 * 2)) - 196608);
      default: return 32'($urandom_range(65536));
    endcase
  endfunction

  initial begin
    logic [31:0] s_pick, t_pick;
    logic [1:0] wrap_pick [4] = '{tsw_pkg::WRAP_CLAMP, tsw_pkg::WRAP_REPEAT,
                                  tsw_pkg::WRAP_MIRROR, 2'd3};
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // fill the four corner blocks so wrapped edges read defined texels
    for (int y = 0; y < tsw_pkg::MaxHeight; y++)
      for (int x = 0; x < tsw_pkg::MaxWidth; x++)
        if ((x < 16 || x >= 48) && (y < 16 || y >= 48))
          write_texel(x, y, (x == 0 && y == 0) ? 32'hFFFFFFFF :
                            (x == 63 && y == 63) ? 32'h00000000 : $urandom());
    // directed: field extremes, each wrap mode, both filters, size extremes
    sample_at(32'h0, 32'h0);
    sample_at(32'h7FFFFFFF, 32'h80000000);
    sample_at(32'h80000000, 32'h7FFFFFFF);
    sample_at(32'hFFFFFFFF, 32'h00010000);
    configure(1, 1, tsw_pkg::WRAP_CLAMP, tsw_pkg::WRAP_MIRROR, tsw_pkg::FILT_NEAREST);
    sample_at(32'h00008000, 32'hFFFF8000);
    sample_at(32'h7FFFFFFF, 32'h80000000);
    configure(0, 127, 2'd3, tsw_pkg::WRAP_REPEAT, tsw_pkg::FILT_BILINEAR);
    sample_at(32'h00018000, 32'hFFFE0000);
    sample_at(32'h80000000, 32'h7FFFFFFF);
    configure(64, 1, tsw_pkg::WRAP_MIRROR, tsw_pkg::WRAP_CLAMP, tsw_pkg::FILT_BILINEAR);
    sample_at(32'h0001C000, 32'h00020000);
    sample_at(32'hFFFF4000, 32'h0000FF00);
    configure(37, 64, tsw_pkg::WRAP_MIRROR, tsw_pkg::WRAP_MIRROR, tsw_pkg::FILT_NEAREST);
    sample_at(32'h00017FFF, 32'hFFFE8001);
    write_texel(5, 6, 32'h12345678);
    sample_at(32'h00002000, 32'h00003000);

    // random phases over idling patterns and register settings
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      configure((ph == 5) ? 1 : (ph == 6) ? 64 : $urandom_range(1, 64),
                (ph == 7) ? 1 : (ph == 8) ? 64 : $urandom_range(1, 64),
                wrap_pick[$urandom_range(3)], wrap_pick[$urandom_range(3)],
                1'($urandom_range(1)));
      for (int i = 0; i < 38; i++) begin
        if ($urandom_range(4) == 0)
          write_texel($urandom_range(63), $urandom_range(63), $urandom());
        else begin
          s_pick = rand_coord(); t_pick = rand_coord();
          for (int k = 0; k < 16 && !color_sb.can_sample(s_pick, t_pick); k++) begin
            s_pick = rand_coord(); t_pick = rand_coord();
          end
          sample_at(s_pick, t_pick);
        end
      end
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    drain();
    if (color_sb.errors == 0 && color_sb.pending_rgba.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/tsw_pkg.sv
hw/rtl/tsw_queue.sv
hw/rtl/tsw_front.sv
hw/rtl/tsw_back.sv
hw/rtl/texture_sampler_wrap_bilinear_top.sv
sim/texture_sampler_wrap_bilinear_top_tb.sv
